// ===== rtl/bcba_pkg.sv =====
// ----------------------------------------------------------------------------
// bcba_pkg
// Shared widths, action codes and status codes of the contiguous block
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bcba_pkg;

	localparam int MAP_BLOCKS_DEF = 65536;
	localparam int WORD_BITS      = 64;
	localparam int OFF_W          = 6;

	localparam int ACT_W = 2;
	localparam int LEN_W = 13;
	localparam int BLK_W = 17;
	localparam int CNT_W = 17;
	localparam int ST_W  = 2;

	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MARK  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_RUN = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/bitmap_contiguous_block_allocator.sv =====
// Mark-used and free pass through S_BIT_RD, S_BIT_WR and S_RESP after acceptance.
// Allocation scans one 64-bit bitmap word per cycle: up to MAP_WORDS words (1024 at
// the default size), up to twice that when the scan is retried from block zero, then
// a read and a write (S_CLR_RD, S_CLR_WR) for each bitmap word the found run touches.
// One transaction is in work at a time; the bitmap memory port sets the scan rate.
// After reset a fill pass writes MAP_WORDS words before input is taken.
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator
// First-fit allocator of contiguous block runs over a free-block bitmap held in
// a 64-bit wide memory, with a roving search start and a free-block count.
// ----------------------------------------------------------------------------
`default_nettype none
module bitmap_contiguous_block_allocator #(
	parameter int MAP_BLOCKS = bcba_pkg::MAP_BLOCKS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [bcba_pkg::ACT_W-1:0]  action,
	input  wire logic [bcba_pkg::LEN_W-1:0]  run_length,
	input  wire logic [bcba_pkg::BLK_W-1:0]  block,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [bcba_pkg::BLK_W-1:0]       start_block,
	output logic [bcba_pkg::CNT_W-1:0]       free_count,
	output logic [bcba_pkg::ST_W-1:0]        status
);
	import bcba_pkg::*;

	localparam int MAP_WORDS = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(MAP_BLOCKS + 1);
	localparam int PW        = (AW + OFF_W > BW) ? AW + OFF_W : BW;
	localparam int SW        = (BW > LEN_W) ? BW : LEN_W;
	localparam int REM       = MAP_BLOCKS % WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_FILL =
		(REM == 0) ? {WORD_BITS{1'b1}} : ((64'd1 << REM) - 64'd1);
	localparam logic [AW-1:0] LAST_IDX = AW'(MAP_WORDS - 1);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_SCAN, S_CLR_RD, S_CLR_WR, S_BIT_RD, S_BIT_WR, S_RESP
	} state_t;

	// Number of consecutive ones from bit 0 upward.
	function automatic logic [6:0] trail_ones(input logic [WORD_BITS-1:0] w);
		logic [6:0] n;
		n = 7'd64;
		for (int i = WORD_BITS - 1; i >= 0; i--)
			if (!w[i]) n = 7'(i);
		return n;
	endfunction

	// Number of consecutive ones from bit 63 downward.
	function automatic logic [6:0] lead_ones(input logic [WORD_BITS-1:0] w);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 0; i < WORD_BITS; i++)
			if (!w[i]) n = 7'(WORD_BITS - 1 - i);
		return n;
	endfunction

	function automatic logic [OFF_W-1:0] low_set(input logic [WORD_BITS-1:0] w);
		logic [OFF_W-1:0] n;
		n = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--)
			if (w[i]) n = OFF_W'(i);
		return n;
	endfunction

	// Bit p is set when bits p .. p+len-1 of w are all set (len 1 to 64). The
	// doubling steps build runs of 2^j; one extra shift covers the remainder.
	function automatic logic [WORD_BITS-1:0] run_mask(input logic [WORD_BITS-1:0] w,
			input logic [6:0] len);
		logic [WORD_BITS-1:0] a [7];
		logic [WORD_BITS-1:0] p;
		logic [2:0]           hb;
		logic [6:0]           sh;
		a[0] = w;
		for (int j = 1; j < 7; j++)
			a[j] = a[j-1] & (a[j-1] >> (1 << (j - 1)));
		hb = '0;
		for (int j = 0; j < 7; j++)
			if (len[j]) hb = 3'(j);
		p  = a[hb];
		sh = len - (7'd1 << hb);
		return p & (p >> sh);
	endfunction

	state_t state_q;

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_wa, mem_ra;
	logic [WORD_BITS-1:0] mem_wd;

	logic [AW-1:0]    clr_idx_q;
	logic [BW-1:0]    free_total_q;
	logic [PW-1:0]    search_start_q;
	logic [LEN_W-1:0] len_q;
	logic [AW-1:0]    from_word_q;
	logic [OFF_W-1:0] from_off_q;
	logic [AW-1:0]    rd_idx_q;
	logic [AW-1:0]    widx_q;
	logic             more_q;
	logic             rvld_q;
	logic             retried_q;
	logic [LEN_W-1:0] run_q;
	logic [PW-1:0]    start_q;
	logic [PW-1:0]    s_q;
	logic [AW-1:0]    cw_q, first_w_q, last_w_q;
	logic [OFF_W-1:0] lo_off_q;
	logic [6:0]       hi_off_q;
	logic [PW-1:0]    bit_q;
	logic             set_q;
	logic [BLK_W-1:0] res_start_q;
	logic [ST_W-1:0]  res_status_q;
	logic             out_valid_q;
	logic [BLK_W-1:0] start_block_q;
	logic [CNT_W-1:0] free_count_q;
	logic [ST_W-1:0]  status_q;

	// Scan datapath: one bitmap word per cycle.
	logic [PW-1:0]        base;
	logic [WORD_BITS-1:0] w_m, rm;
	logic [6:0]           pre, suf;
	logic                 all_one, found_c, found_i;
	logic [LEN_W:0]       carry_sum;
	logic [PW-1:0]        start_sel, start_next;
	logic [LEN_W-1:0]     run_next;
	logic [PW:0]          run_end;
	logic [6:0]           lo_sel, hi_sel;
	logic [WORD_BITS:0]   clr_mask_w;
	logic [WORD_BITS-1:0] clr_mask, bit_mask;

	always_comb begin
		base      = PW'({widx_q, {OFF_W{1'b0}}});
		w_m       = rdata_q;
		if (widx_q == from_word_q)
			w_m = rdata_q & ({WORD_BITS{1'b1}} << from_off_q);
		pre       = trail_ones(w_m);
		suf       = lead_ones(w_m);
		all_one   = &w_m;
		rm        = (len_q <= LEN_W'(WORD_BITS)) ? run_mask(w_m, len_q[6:0]) : '0;
		carry_sum = (LEN_W + 1)'(run_q) + (LEN_W + 1)'(pre);
		found_c   = carry_sum >= {1'b0, len_q};
		found_i   = |rm;
		if (found_c)
			start_sel = (run_q == '0) ? base : start_q;
		else
			start_sel = base + PW'(low_set(rm));
		run_end   = (PW + 1)'(start_sel) + (PW + 1)'(len_q) - (PW + 1)'(1);
		if (all_one) begin
			run_next   = LEN_W'(run_q + LEN_W'(WORD_BITS));
			start_next = (run_q == '0) ? base : start_q;
		end else begin
			run_next   = LEN_W'(suf);
			start_next = base + PW'(7'd64 - suf);
		end
	end

	always_comb begin
		lo_sel     = (cw_q == first_w_q) ? {1'b0, lo_off_q} : 7'd0;
		hi_sel     = (cw_q == last_w_q) ? hi_off_q : 7'd64;
		clr_mask_w = ((65'd1 << hi_sel) - 65'd1) & ~((65'd1 << lo_sel) - 65'd1);
		clr_mask   = clr_mask_w[WORD_BITS-1:0];
		bit_mask   = 64'd1 << bit_q[OFF_W-1:0];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = cw_q;
		mem_ra = cw_q;
		mem_wd = rdata_q & ~clr_mask;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_idx_q;
				mem_wd = (clr_idx_q == LAST_IDX) ? LAST_FILL : {WORD_BITS{1'b1}};
			end
			S_SCAN: begin
				mem_re = more_q;
				mem_ra = rd_idx_q;
			end
			S_CLR_RD: mem_re = 1'b1;
			S_CLR_WR: mem_we = 1'b1;
			S_BIT_RD: begin
				mem_re = 1'b1;
				mem_ra = AW'(bit_q >> OFF_W);
			end
			S_BIT_WR: begin
				mem_we = 1'b1;
				mem_wa = AW'(bit_q >> OFF_W);
				mem_wd = set_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_idx_q      <= '0;
			free_total_q   <= BW'(MAP_BLOCKS);
			search_start_q <= '0;
			len_q          <= '0;
			from_word_q    <= '0;
			from_off_q     <= '0;
			rd_idx_q       <= '0;
			widx_q         <= '0;
			more_q         <= 1'b0;
			rvld_q         <= 1'b0;
			retried_q      <= 1'b0;
			run_q          <= '0;
			start_q        <= '0;
			s_q            <= '0;
			cw_q           <= '0;
			first_w_q      <= '0;
			last_w_q       <= '0;
			lo_off_q       <= '0;
			hi_off_q       <= '0;
			bit_q          <= '0;
			set_q          <= 1'b0;
			res_start_q    <= '0;
			res_status_q   <= ST_OK;
			out_valid_q    <= 1'b0;
			start_block_q  <= '0;
			free_count_q   <= '0;
			status_q       <= ST_OK;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_RESP)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (clr_idx_q == LAST_IDX)
						state_q <= S_IDLE;
					else
						clr_idx_q <= clr_idx_q + AW'(1);
				end
				S_IDLE: begin
					if (in_valid) begin
						len_q        <= run_length;
						res_start_q  <= '0;
						case (action)
							ACT_ALLOC: begin
								run_q  <= '0;
								rvld_q <= 1'b0;
								more_q <= 1'b1;
								if (run_length == '0) begin
									search_start_q <= '0;
									res_status_q   <= ST_NO_RUN;
									state_q        <= S_RESP;
								end else if (search_start_q >= PW'(MAP_BLOCKS)) begin
									// The first pass cannot find anything: go straight
									// to the retry from block zero.
									search_start_q <= '0;
									from_word_q    <= '0;
									from_off_q     <= '0;
									rd_idx_q       <= '0;
									retried_q      <= 1'b1;
									res_status_q   <= ST_OK;
									state_q        <= S_SCAN;
								end else begin
									from_word_q  <= AW'(search_start_q >> OFF_W);
									from_off_q   <= search_start_q[OFF_W-1:0];
									rd_idx_q     <= AW'(search_start_q >> OFF_W);
									retried_q    <= (search_start_q == '0);
									res_status_q <= ST_OK;
									state_q      <= S_SCAN;
								end
							end
							ACT_MARK, ACT_FREE: begin
								if (block == '0 || 32'(block) > 32'(MAP_BLOCKS)) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_RESP;
								end else begin
									bit_q        <= PW'(block - BLK_W'(1));
									set_q        <= (action == ACT_FREE);
									res_status_q <= ST_OK;
									state_q      <= S_BIT_RD;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					rvld_q <= more_q;
					widx_q <= rd_idx_q;
					if (more_q) begin
						if (rd_idx_q == LAST_IDX)
							more_q <= 1'b0;
						else
							rd_idx_q <= rd_idx_q + AW'(1);
					end
					if (rvld_q) begin
						if (found_c || found_i) begin
							s_q       <= start_sel;
							cw_q      <= AW'(start_sel >> OFF_W);
							first_w_q <= AW'(start_sel >> OFF_W);
							last_w_q  <= AW'(run_end >> OFF_W);
							lo_off_q  <= start_sel[OFF_W-1:0];
							hi_off_q  <= {1'b0, run_end[OFF_W-1:0]} + 7'd1;
							state_q   <= S_CLR_RD;
						end else begin
							start_q <= start_next;
							if (widx_q == LAST_IDX) begin
								// The last word's read is the final one in flight, so
								// more_q is already low here.
								search_start_q <= '0;
								run_q          <= '0;
								if (!retried_q) begin
									from_word_q <= '0;
									from_off_q  <= '0;
									rd_idx_q    <= '0;
									more_q      <= 1'b1;
									retried_q   <= 1'b1;
								end else begin
									res_status_q <= ST_NO_RUN;
									state_q      <= S_RESP;
								end
							end else begin
								run_q <= run_next;
							end
						end
					end
				end
				S_CLR_RD: state_q <= S_CLR_WR;
				S_CLR_WR: begin
					if (cw_q == last_w_q) begin
						if (SW'(free_total_q) >= SW'(len_q))
							free_total_q <= BW'(SW'(free_total_q) - SW'(len_q));
						else
							free_total_q <= '0;
						search_start_q <= PW'((PW + 1)'(search_start_q) + (PW + 1)'(len_q));
						res_start_q    <= BLK_W'((PW + 1)'(s_q) + (PW + 1)'(1));
						state_q        <= S_RESP;
					end else begin
						cw_q    <= cw_q + AW'(1);
						state_q <= S_CLR_RD;
					end
				end
				S_BIT_RD: state_q <= S_BIT_WR;
				S_BIT_WR: begin
					// The count moves even when the bit already had the new value.
					if (set_q) begin
						if (free_total_q < BW'(MAP_BLOCKS))
							free_total_q <= free_total_q + BW'(1);
					end else if (free_total_q != '0) begin
						free_total_q <= free_total_q - BW'(1);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						start_block_q <= res_start_q;
						free_count_q  <= CNT_W'(free_total_q);
						status_q      <= res_status_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign start_block = start_block_q;
	assign free_count  = free_count_q;
	assign status      = status_q;

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_total_q <= BW'(MAP_BLOCKS))
		else $error("free count exceeds the number of blocks");

	a_start_bound: assert property (@(posedge clk) disable iff (!arst_n)
		search_start_q <= PW'(MAP_BLOCKS))
		else $error("search start ran past the end of the map");

	a_run_short: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> run_q < len_q)
		else $error("carried run reached the requested length without a hit");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != S_IDLE)
		else $error("accepted transaction did not start work");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_NO_RUN || status_q == ST_RANGE) |->
			start_block_q == '0)
		else $error("failed transaction reports a start block");

endmodule
`default_nettype wire

// ===== tb/tb_bitmap_contiguous_block_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_contiguous_block_allocator
// Self-checking bench for the first-fit contiguous block allocator. A short
// table of directed requests runs first. It is followed by random bursts of
// hole punching, allocations, redundant marks and frees, and out-of-range noise,
// under several idle and stall patterns. A shadow bitmap predicts each reply
// not given literally by the table; each is checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_bitmap_contiguous_block_allocator;
	import bcba_pkg::*;

	localparam int MAP_BLOCKS = MAP_BLOCKS_DEF;
	localparam int MAP_WORDS = MAP_BLOCKS / WORD_BITS;
	localparam int BLK_MAX = (1 << BLK_W) - 1;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 140;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 2 * MAP_WORDS + 200;
	localparam int CYCLE_LIMIT = 6000000;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [LEN_W-1:0] len;
		logic [BLK_W-1:0] blk;
	} req_t;

	typedef struct packed {
		logic [BLK_W-1:0] start;
		logic [CNT_W-1:0] count;
		logic [ST_W-1:0]  st;
	} reply_t;

	typedef struct {
		req_t   req;
		int     reps;
		bit     lit;
		reply_t reply;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [ACT_W-1:0]    action = '0;
	logic [LEN_W-1:0]    run_length = '0;
	logic [BLK_W-1:0]    block = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [BLK_W-1:0]    start_block;
	logic [CNT_W-1:0]    free_count;
	logic [ST_W-1:0]     status;

	// Literal reply that travels with the request currently offered.
	bit                  lit_on = 1'b0;
	reply_t              lit_reply = '0;

	// Shadow allocator state.
	bit [WORD_BITS-1:0]  shadow_words [MAP_WORDS];
	int unsigned         shadow_free;
	int unsigned         shadow_pos;

	reply_t              reply_q [$];
	req_t                burst_q [$];
	row_t                directed_rows [$];

	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int                  hold_ticket = 0;
	int                  hold_seen = 0;
	int                  hold_left = 0;
	int                  cycle_count = 0;
	int                  fail_count = 0;
	int                  items_sent = 0;
	int                  n_granted = 0;
	int                  n_refused = 0;
	int                  n_range = 0;
	int                  n_checked = 0;
	int                  last_hole = 1;

	reply_t              predicted;
	reply_t              want;

	bitmap_contiguous_block_allocator #(
		.MAP_BLOCKS(MAP_BLOCKS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.run_length(run_length),
		.block(block),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.start_block(start_block),
		.free_count(free_count),
		.status(status)
	);

	always #6 clk = ~clk;

	// First-fit search for len free bits at or after bit position from.
	function automatic bit seek_run(input int unsigned from, input int unsigned len,
			output int unsigned at);
		int unsigned idx;
		int unsigned run;
		int unsigned s;
		at = 0;
		if (len == 0)
			return 1'b0;
		idx = from;
		run = 0;
		s = 0;
		while (idx < MAP_BLOCKS) begin
			if (run == 0 && (idx & 63) == 0 && shadow_words[idx >> 6] == '0) begin
				idx += 64;
				continue;
			end
			if (shadow_words[idx >> 6][idx & 63]) begin
				if (run == 0)
					s = idx;
				run++;
				if (run == len) begin
					at = s;
					return 1'b1;
				end
			end else begin
				run = 0;
			end
			idx++;
		end
		return 1'b0;
	endfunction

	task automatic shadow_reset();
		for (int w = 0; w < MAP_WORDS; w++)
			shadow_words[w] = '1;
		shadow_free = MAP_BLOCKS;
		shadow_pos = 0;
	endtask

	// Applies one request to the shadow state and returns the reply it causes.
	task automatic bitmap_step(input req_t r, output reply_t rep);
		bit found;
		int unsigned at;
		int unsigned b;
		rep = '0;
		if (r.act == ACT_ALLOC) begin
			found = seek_run(shadow_pos, r.len, at);
			if (!found) begin
				shadow_pos = 0;
				found = seek_run(0, r.len, at);
			end
			if (found) begin
				for (int unsigned k = 0; k < r.len; k++)
					shadow_words[(at + k) >> 6][(at + k) & 63] = 1'b0;
				shadow_free = (shadow_free >= r.len) ? shadow_free - r.len : 0;
				shadow_pos += r.len;
				rep.start = BLK_W'(at + 1);
				n_granted++;
			end else begin
				rep.st = ST_NO_RUN;
				n_refused++;
			end
		end else if (r.act == ACT_MARK || r.act == ACT_FREE) begin
			if (r.blk == 0 || r.blk > MAP_BLOCKS) begin
				rep.st = ST_RANGE;
				n_range++;
			end else begin
				b = r.blk - 1;
				if (r.act == ACT_MARK) begin
					shadow_words[b >> 6][b & 63] = 1'b0;
					if (shadow_free > 0)
						shadow_free--;
				end else begin
					shadow_words[b >> 6][b & 63] = 1'b1;
					if (shadow_free < MAP_BLOCKS)
						shadow_free++;
				end
			end
		end
		rep.count = shadow_free[CNT_W-1:0];
	endtask

	function automatic req_t mk_req(input logic [ACT_W-1:0] a, input int len, input int blk);
		req_t r;
		r.act = a;
		r.len = len[LEN_W-1:0];
		r.blk = blk[BLK_W-1:0];
		return r;
	endfunction

	task automatic add_row(input logic [ACT_W-1:0] a, input int len, input int blk,
			input int reps, input bit lit, input int start, input int count,
			input logic [ST_W-1:0] st);
		row_t row;
		row.req = mk_req(a, len, blk);
		row.reps = reps;
		row.lit = lit;
		row.reply.start = start[BLK_W-1:0];
		row.reply.count = count[CNT_W-1:0];
		row.reply.st = st;
		directed_rows.push_back(row);
	endtask

	function automatic int pick_length();
		int p;
		p = $urandom_range(99);
		if (p < 50)
			return $urandom_range(1, 4);
		else if (p < 80)
			return $urandom_range(5, 64);
		else if (p < 95)
			return $urandom_range(65, 4096);
		return 0;
	endfunction

	// Queues one burst of related requests. The most common burst frees a short span
	// and then allocates into it, often across a word boundary.
	task automatic plan_burst();
		int p;
		int span;
		int bit0;
		int b;
		logic [ACT_W-1:0] a;
		p = $urandom_range(99);
		if (p < 35) begin
			span = $urandom_range(1, 16);
			if ($urandom_range(99) < 30)
				bit0 = 64 * $urandom_range(1, MAP_WORDS - 1) - $urandom_range(0, span - 1);
			else
				bit0 = $urandom_range(0, MAP_BLOCKS - span);
			last_hole = bit0 + 1;
			for (int k = 0; k < span; k++)
				burst_q.push_back(mk_req(ACT_FREE, $urandom_range(0, 4096), bit0 + 1 + k));
			if ($urandom_range(99) < 70)
				burst_q.push_back(mk_req(ACT_ALLOC, $urandom_range(1, span),
					$urandom_range(1, MAP_BLOCKS)));
			else
				burst_q.push_back(mk_req(ACT_ALLOC, span + $urandom_range(1, 4),
					$urandom_range(1, MAP_BLOCKS)));
		end else if (p < 55) begin
			burst_q.push_back(mk_req(ACT_ALLOC, pick_length(), $urandom_range(1, MAP_BLOCKS)));
		end else if (p < 70) begin
			if ($urandom_range(1))
				b = last_hole + $urandom_range(0, 15);
			else
				b = $urandom_range(1, MAP_BLOCKS);
			if (b > MAP_BLOCKS)
				b = MAP_BLOCKS;
			burst_q.push_back(mk_req(ACT_MARK, $urandom_range(0, 4096), b));
		end else if (p < 80) begin
			burst_q.push_back(mk_req(ACT_FREE, $urandom_range(0, 4096),
				$urandom_range(1, MAP_BLOCKS)));
		end else if (p < 90) begin
			// The second transaction of the pair finds the bit already in its state.
			a = $urandom_range(1) ? ACT_MARK : ACT_FREE;
			b = $urandom_range(1, MAP_BLOCKS);
			burst_q.push_back(mk_req(a, $urandom_range(0, 4096), b));
			burst_q.push_back(mk_req(a, $urandom_range(0, 4096), b));
		end else begin
			a = $urandom_range(1) ? ACT_MARK : ACT_FREE;
			case ($urandom_range(3))
				0: burst_q.push_back(mk_req(a, $urandom_range(0, 4096), 0));
				1: burst_q.push_back(mk_req(a, $urandom_range(0, 4096),
					$urandom_range(MAP_BLOCKS + 1, BLK_MAX)));
				2: burst_q.push_back(mk_req(ACT_UNUSED, $urandom_range(0, 4096),
					$urandom_range(0, BLK_MAX)));
				default: burst_q.push_back(mk_req(ACT_ALLOC, 0, $urandom_range(1, MAP_BLOCKS)));
			endcase
		end
	endtask

	// Offers one request from a falling edge and returns at the falling edge
	// that follows its acceptance.
	task automatic send_item(input req_t r, input bit lit, input reply_t lr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= r.act;
		run_length <= r.len;
		block <= r.blk;
		lit_on <= lit;
		lit_reply <= lr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off counted here.
	always @(negedge clk) begin
		if (hold_seen != hold_ticket) begin
			hold_seen = hold_ticket;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				bitmap_step(mk_req(action, int'(run_length), int'(block)), predicted);
				reply_q.push_back(lit_on ? lit_reply : predicted);
			end
			if (out_valid && !out_stall) begin
				n_checked++;
				if (reply_q.size() == 0) begin
					$error("reply with no request waiting: start_block %0d free_count %0d status %0d",
						start_block, free_count, status);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (start_block !== want.start) begin
						$error("start_block: expected %0d, got %0d", want.start, start_block);
						fail_count++;
					end
					if (free_count !== want.count) begin
						$error("free_count: expected %0d, got %0d", want.count, free_count);
						fail_count++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		shadow_reset();

		add_row(ACT_ALLOC, 0, 1, 1, 1'b1, 0, MAP_BLOCKS, ST_NO_RUN);
		add_row(ACT_FREE, 0, 1, 1, 1'b1, 0, MAP_BLOCKS, ST_OK);
		add_row(ACT_MARK, 0, 0, 1, 1'b1, 0, MAP_BLOCKS, ST_RANGE);
		add_row(ACT_FREE, 4096, BLK_MAX, 1, 1'b1, 0, MAP_BLOCKS, ST_RANGE);
		add_row(ACT_UNUSED, 4096, BLK_MAX, 1, 1'b1, 0, MAP_BLOCKS, ST_OK);
		add_row(ACT_ALLOC, 4096, 0, 1, 1'b1, 1, MAP_BLOCKS - 4096, ST_OK);
		// Fill the rest of the map so that the search start lands on the end.
		add_row(ACT_ALLOC, 4096, 0, MAP_BLOCKS / 4096 - 1, 1'b0, 0, 0, ST_OK);
		add_row(ACT_MARK, 0, MAP_BLOCKS, 1, 1'b1, 0, 0, ST_OK);
		add_row(ACT_FREE, 0, 5, 1, 1'b0, 0, 0, ST_OK);
		add_row(ACT_ALLOC, 1, 0, 1, 1'b0, 0, 0, ST_OK);
		add_row(ACT_ALLOC, 1, 0, 1, 1'b0, 0, 0, ST_OK);
		add_row(ACT_FREE, 0, MAP_BLOCKS, 1, 1'b0, 0, 0, ST_OK);
		add_row(ACT_ALLOC, 1, 0, 1, 1'b0, 0, 0, ST_OK);
		add_row(ACT_ALLOC, 4096, 0, 1, 1'b0, 0, 0, ST_OK);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			for (int r = 0; r < directed_rows[i].reps; r++)
				send_item(directed_rows[i].req, directed_rows[i].lit, directed_rows[i].reply);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 58; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 58; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 0 && n == 40)
					hold_ticket++;
				if (burst_q.size() == 0)
					plan_burst();
				send_item(burst_q.pop_front(), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;
		recv_stall_pct = 0;

		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests and checked %0d replies in %0d cycles.",
			items_sent, n_checked, cycle_count);
		$display("Runs granted %0d, refused %0d, blocks out of range %0d.",
			n_granted, n_refused, n_range);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
